// ----- src/dsp_pkg.sv -----
// shared constants, payload types and control structs of the shortest path block
package dsp_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 256;
   localparam int WEIGHT_BITS  = 16;

   localparam int VERT_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W   = 7;
   localparam int EDGE_AW = $clog2(MAX_EDGES);
   localparam int LINK_W  = EDGE_AW + 1;
   localparam int DIST_W  = 22;

   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_EDGES);
   localparam logic [DIST_W-1:0] DIST_INF  = {DIST_W{1'b1}};

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_RUN   = 2'd2;
   // spare command code, ignored by the block
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [5:0]  edge_from;
      logic [5:0]  edge_to;
      logic [15:0] edge_weight;
      logic [5:0]  start_vertex;
      logic [5:0]  goal_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] vertex_id;
      logic [5:0] parent_vertex;
      logic       has_parent;
      logic       last;
   } rsp_type;

   // edge store control from the sequencer
   typedef struct packed {
      logic                   clear;
      logic                   add;
      logic [VERT_W-1:0]      head_addr;
      logic [EDGE_AW-1:0]     edge_addr;
      logic [VERT_W-1:0]      add_from;
      logic [5:0]             add_to;
      logic [WEIGHT_BITS-1:0] add_cost;
   } es_ctl_type;

   // edge store status back to the sequencer
   typedef struct packed {
      logic                   full;
      logic [LINK_W-1:0]      head_ptr;
      logic [5:0]             dest;
      logic [WEIGHT_BITS-1:0] cost;
      logic [LINK_W-1:0]      link;
   } es_stat_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_ADD   = 9'b000000010,
      S_SCAN  = 9'b000000100,
      S_PICK  = 9'b000001000,
      S_HEAD  = 9'b000010000,
      S_EDGE  = 9'b000100000,
      S_DIST  = 9'b001000000,
      S_RELAX = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

endpackage

// ----- src/dijkstra_shortest_path.sv -----
// top level: command decode, search sequencer, distance and parent memories
// Commands are taken on start while busy is low. Clear graph gives no result and
// leaves the block idle; add edge replies from the add state through the result
// register (straight from acceptance on a range or full error). A run selects
// vertices by scanning the distance memory one vertex a cycle, fetches the list
// head of each settled vertex and relaxes each outgoing edge through the edge,
// dist and relax states over the edge memory and distance memory ports, then
// reports one result per vertex at one per cycle. Results appear on rsp_data for
// exactly one cycle with rsp_strobe and cannot be held off. vertex_count must be
// written only while the block is idle; the block itself does not enforce it.
// csr_ready is always high.
module dijkstra_shortest_path (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dsp_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dsp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [6:0]       csr_wdata
);

   localparam int VW = dsp_pkg::VERT_W;
   localparam int CW = dsp_pkg::CNT_W;
   localparam int DW = dsp_pkg::DIST_W;

   dsp_pkg::state_type state_ff, state_in;
   dsp_pkg::req_type   req_ff, req_in;
   dsp_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic [VW-1:0]      pipe_idx_ff, pipe_idx_in;
   logic [DW-1:0]      best_ff, best_in;
   logic               found_ff, found_in;
   logic [VW-1:0]      sel_ff, sel_in;
   logic [dsp_pkg::LINK_W-1:0] e_ff, e_in;
   logic [5:0]                 dest_ff, dest_in;
   logic [dsp_pkg::WEIGHT_BITS-1:0] cost_ff, cost_in;
   logic [dsp_pkg::LINK_W-1:0] link_ff, link_in;
   logic [dsp_pkg::MAX_VERTICES-1:0] settled_ff, settled_in;
   logic [dsp_pkg::MAX_VERTICES-1:0] touched_ff, touched_in;
   logic [dsp_pkg::MAX_VERTICES-1:0] pw_ff, pw_in;

   logic [DW-1:0] dist_mem [dsp_pkg::MAX_VERTICES];
   logic [VW-1:0] pred_mem [dsp_pkg::MAX_VERTICES];
   logic [DW-1:0] dist_q_ff;
   logic          touched_q_ff;
   logic [VW-1:0] pred_q_ff;

   logic          dist_we, pred_we;
   logic [VW-1:0] dist_waddr, dist_raddr, pred_waddr, pred_raddr;
   logic [DW-1:0] dist_wdata, dist_eff, new_dist;
   logic [DW:0]   dist_sum;
   logic          accept;

   dsp_pkg::es_ctl_type  es_ctl;
   dsp_pkg::es_stat_type es_stat;

   dsp_edge_store u_edge_store (
      .clock   (clock),
      .reset   (reset),
      .es_ctl  (es_ctl),
      .es_stat (es_stat)
   );

   assign busy       = (state_ff != dsp_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // distance read as infinity until touched in this run
   assign dist_eff = touched_q_ff ? dist_q_ff : dsp_pkg::DIST_INF;

   // saturating adder for relaxation
   assign dist_sum = {1'b0, best_ff} + (DW + 1)'(cost_ff);
   assign new_dist = (dist_sum >= {1'b0, dsp_pkg::DIST_INF}) ?
                     dsp_pkg::DIST_INF - DW'(1) : dist_sum[DW-1:0];

   // distance and parent memories
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      if (pred_we) begin
         pred_mem[pred_waddr] <= sel_ff;
      end
      dist_q_ff    <= dist_mem[dist_raddr];
      touched_q_ff <= touched_ff[dist_raddr];
      pred_q_ff    <= pred_mem[pred_raddr];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      sel_in        = sel_ff;
      e_in          = e_ff;
      dest_in       = dest_ff;
      cost_in       = cost_ff;
      link_in       = link_ff;
      settled_in    = settled_ff;
      touched_in    = touched_ff;
      pw_in         = pw_ff;
      dist_we       = 1'b0;
      dist_waddr    = req_ff.start_vertex[VW-1:0];
      dist_wdata    = new_dist;
      dist_raddr    = cnt_ff[VW-1:0];
      pred_we       = 1'b0;
      pred_waddr    = dest_ff[VW-1:0];
      pred_raddr    = cnt_ff[VW-1:0];
      es_ctl.clear     = 1'b0;
      es_ctl.add       = 1'b0;
      es_ctl.head_addr = req_data.edge_from[VW-1:0];
      es_ctl.edge_addr = e_ff[dsp_pkg::EDGE_AW-1:0];
      es_ctl.add_from  = req_ff.edge_from[VW-1:0];
      es_ctl.add_to    = req_ff.edge_to;
      es_ctl.add_cost  = req_ff.edge_weight[dsp_pkg::WEIGHT_BITS-1:0];

      // configuration write with clamping
      if (csr_valid) begin
         if (csr_wdata == 7'd0) begin
            n_in = CW'(1);
         end else if (csr_wdata > CW'(dsp_pkg::MAX_VERTICES)) begin
            n_in = CW'(dsp_pkg::MAX_VERTICES);
         end else begin
            n_in = csr_wdata;
         end
      end

      unique case (state_ff)
         dsp_pkg::S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               rsp_data_in = '{status: dsp_pkg::ST_OK, vertex_id: 6'd0,
                               parent_vertex: 6'd0, has_parent: 1'b0, last: 1'b1};
               case (req_data.cmd)
                  dsp_pkg::CMD_CLEAR: begin
                     es_ctl.clear = 1'b1;
                  end
                  dsp_pkg::CMD_ADD: begin
                     if ({1'b0, req_data.edge_from} >= n_ff ||
                         {1'b0, req_data.edge_to} >= n_ff) begin
                        rsp_data_in.status = dsp_pkg::ST_RANGE;
                        rsp_strobe_in = 1'b1;
                     end else if (es_stat.full) begin
                        rsp_data_in.status = dsp_pkg::ST_FULL;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = dsp_pkg::S_ADD;
                     end
                  end
                  dsp_pkg::CMD_RUN: begin
                     if ({1'b0, req_data.start_vertex} >= n_ff ||
                         {1'b0, req_data.goal_vertex} >= n_ff) begin
                        rsp_data_in.status = dsp_pkg::ST_RANGE;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        settled_in = '0;
                        pw_in      = '0;
                        touched_in = '0;
                        touched_in[req_data.start_vertex[VW-1:0]] = 1'b1;
                        dist_we    = 1'b1;
                        dist_waddr = req_data.start_vertex[VW-1:0];
                        dist_wdata = '0;
                        cnt_in     = '0;
                        best_in    = dsp_pkg::DIST_INF;
                        found_in   = 1'b0;
                        sel_in     = '0;
                        state_in   = dsp_pkg::S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         dsp_pkg::S_ADD: begin
            es_ctl.add    = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = dsp_pkg::S_IDLE;
         end
         dsp_pkg::S_SCAN: begin
            // issue one read a cycle, compare in the next cycle
            if (cnt_ff != n_ff) begin
               pipe_vld_in = 1'b1;
               pipe_idx_in = cnt_ff[VW-1:0];
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               state_in = dsp_pkg::S_PICK;
            end
            if (pipe_vld_ff && !settled_ff[pipe_idx_ff] && dist_eff < best_ff) begin
               best_in  = dist_eff;
               sel_in   = pipe_idx_ff;
               found_in = 1'b1;
            end
         end
         dsp_pkg::S_PICK: begin
            if (!found_ff || sel_ff == req_ff.goal_vertex[VW-1:0]) begin
               cnt_in   = '0;
               state_in = dsp_pkg::S_OUT;
            end else begin
               settled_in[sel_ff] = 1'b1;
               es_ctl.head_addr   = sel_ff;
               state_in           = dsp_pkg::S_HEAD;
            end
         end
         dsp_pkg::S_HEAD: begin
            e_in     = es_stat.head_ptr;
            state_in = dsp_pkg::S_EDGE;
         end
         dsp_pkg::S_EDGE: begin
            if (e_ff == dsp_pkg::LINK_NULL) begin
               cnt_in   = '0;
               best_in  = dsp_pkg::DIST_INF;
               found_in = 1'b0;
               state_in = dsp_pkg::S_SCAN;
            end else begin
               state_in = dsp_pkg::S_DIST;
            end
         end
         dsp_pkg::S_DIST: begin
            dest_in    = es_stat.dest;
            cost_in    = es_stat.cost;
            link_in    = es_stat.link;
            dist_raddr = es_stat.dest[VW-1:0];
            state_in   = dsp_pkg::S_RELAX;
         end
         dsp_pkg::S_RELAX: begin
            // strict improvement on an unsettled in-range neighbor
            if ({1'b0, dest_ff} < n_ff && !settled_ff[dest_ff[VW-1:0]] &&
                new_dist < dist_eff) begin
               dist_we    = 1'b1;
               dist_waddr = dest_ff[VW-1:0];
               dist_wdata = new_dist;
               pred_we    = 1'b1;
               touched_in[dest_ff[VW-1:0]] = 1'b1;
               pw_in[dest_ff[VW-1:0]]      = 1'b1;
            end
            e_in     = link_ff;
            state_in = dsp_pkg::S_EDGE;
         end
         dsp_pkg::S_OUT: begin
            // one result per vertex, parent read in the cycle before the result is built
            if (cnt_ff != n_ff) begin
               pipe_vld_in = 1'b1;
               pipe_idx_in = cnt_ff[VW-1:0];
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               state_in = dsp_pkg::S_IDLE;
            end
            if (pipe_vld_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in.status        = dsp_pkg::ST_OK;
               rsp_data_in.vertex_id     = 6'(pipe_idx_ff);
               rsp_data_in.has_parent    = pw_ff[pipe_idx_ff];
               rsp_data_in.parent_vertex = pw_ff[pipe_idx_ff] ? 6'(pred_q_ff) : 6'd0;
               rsp_data_in.last = ({1'b0, pipe_idx_ff} == n_ff - CW'(1));
            end
         end
         default: begin
            state_in = dsp_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dsp_pkg::S_IDLE;
         rsp_strobe_ff <= 1'b0;
         n_ff          <= CW'(dsp_pkg::MAX_VERTICES);
         pipe_vld_ff   <= 1'b0;
         settled_ff    <= '0;
         touched_ff    <= '0;
         pw_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         n_ff          <= n_in;
         pipe_vld_ff   <= pipe_vld_in;
         settled_ff    <= settled_in;
         touched_ff    <= touched_in;
         pw_ff         <= pw_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      cnt_ff      <= cnt_in;
      pipe_idx_ff <= pipe_idx_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      sel_ff      <= sel_in;
      e_ff        <= e_in;
      dest_ff     <= dest_in;
      cost_ff     <= cost_in;
      link_ff     <= link_in;
   end

endmodule

// ----- src/dsp_edge_store.sv -----
// linked per-vertex edge tables: edge memories, list heads and fill count
module dsp_edge_store (
   input  logic                clock,
   input  logic                reset,
   input  dsp_pkg::es_ctl_type es_ctl,
   output dsp_pkg::es_stat_type es_stat
);

   logic [5:0]                      dest_mem [dsp_pkg::MAX_EDGES];
   logic [dsp_pkg::WEIGHT_BITS-1:0] cost_mem [dsp_pkg::MAX_EDGES];
   logic [dsp_pkg::LINK_W-1:0]      link_mem [dsp_pkg::MAX_EDGES];
   logic [dsp_pkg::EDGE_AW-1:0]     head_mem [dsp_pkg::MAX_VERTICES];

   logic [dsp_pkg::MAX_VERTICES-1:0] head_valid_ff, head_valid_in;
   logic [dsp_pkg::LINK_W-1:0]       used_ff, used_in;
   logic [dsp_pkg::EDGE_AW-1:0]      head_q_ff;
   logic                             head_vld_q_ff;
   logic [5:0]                       dest_q_ff;
   logic [dsp_pkg::WEIGHT_BITS-1:0]  cost_q_ff;
   logic [dsp_pkg::LINK_W-1:0]       link_q_ff;
   logic [dsp_pkg::LINK_W-1:0]       head_ptr;

   // list head seen through its valid bit
   assign head_ptr = head_vld_q_ff ? {1'b0, head_q_ff} : dsp_pkg::LINK_NULL;

   // memory writes and registered reads
   always_ff @(posedge clock) begin
      if (es_ctl.add) begin
         dest_mem[used_ff[dsp_pkg::EDGE_AW-1:0]] <= es_ctl.add_to;
         cost_mem[used_ff[dsp_pkg::EDGE_AW-1:0]] <= es_ctl.add_cost;
         link_mem[used_ff[dsp_pkg::EDGE_AW-1:0]] <= head_ptr;
         head_mem[es_ctl.add_from]              <= used_ff[dsp_pkg::EDGE_AW-1:0];
      end
      head_q_ff     <= head_mem[es_ctl.head_addr];
      head_vld_q_ff <= head_valid_ff[es_ctl.head_addr];
      dest_q_ff     <= dest_mem[es_ctl.edge_addr];
      cost_q_ff     <= cost_mem[es_ctl.edge_addr];
      link_q_ff     <= link_mem[es_ctl.edge_addr];
   end

   // list valid bits and fill count
   always_comb begin
      head_valid_in = head_valid_ff;
      used_in       = used_ff;
      if (es_ctl.clear) begin
         head_valid_in = '0;
         used_in       = '0;
      end else if (es_ctl.add) begin
         head_valid_in[es_ctl.add_from] = 1'b1;
         used_in = used_ff + dsp_pkg::LINK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         used_ff       <= '0;
      end else begin
         head_valid_ff <= head_valid_in;
         used_ff       <= used_in;
      end
   end

   assign es_stat.full     = (used_ff == dsp_pkg::LINK_NULL);
   assign es_stat.head_ptr = head_ptr;
   assign es_stat.dest     = dest_q_ff;
   assign es_stat.cost     = cost_q_ff;
   assign es_stat.link     = link_q_ff;

endmodule

// ----- src/dsp_checker.sv -----
// port-level checker for the shortest path block and its bind
module dsp_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input dsp_pkg::req_type req_data,
   input logic             rsp_strobe,
   input dsp_pkg::rsp_type rsp_data
);

   // status code is always a defined one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status == dsp_pkg::ST_OK ||
                      rsp_data.status == dsp_pkg::ST_FULL ||
                      rsp_data.status == dsp_pkg::ST_RANGE))
      else $error("undefined status code");

   // error replies are single and carry no vertex
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != dsp_pkg::ST_OK |->
         rsp_data.last && rsp_data.vertex_id == 6'd0)
      else $error("error reply malformed");

   // parent is zero unless one was written
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.has_parent |-> rsp_data.parent_vertex == 6'd0)
      else $error("parent without has_parent");

   // clear graph completes at once with no result
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.cmd == dsp_pkg::CMD_CLEAR |=> !busy && !rsp_strobe)
      else $error("clear graph not immediate");

   // reset leaves the block idle and quiet
   assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("not idle after reset");

endmodule

bind dijkstra_shortest_path dsp_port_checker u_dsp_port_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
